>>> hw/rtl/ssw_pkg.sv
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and word mixing functions
// Holds the word kind code, the stage record passed from the premix stage to
// the sum stage, and the parts of the word mixing that do not need the sum.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;

    localparam logic [WORD_W-1:0] FULL_SEED = 32'h0343_2383;
    localparam logic [WORD_W-1:0] TAIL_SEED = 32'h0202_0101;

    localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;

    // How a word updates the running sum.
    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_FULL,
        KIND_TAIL
    } word_kind_t;

    // Contents of the premix register, handed to the sum stage.
    typedef struct packed {
        logic              valid;
        logic              last;
        word_kind_t        kind;
        logic [WORD_W-1:0] term;
    } premix_t;

    // Sum-independent term of a full word.
    function automatic logic [WORD_W-1:0] full_term(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] acc;
        acc = FULL_SEED + w
            + {24'd0, w[31:24]}
            + {15'd0, w[23:16], 9'd0}
            + {8'd0, w[15:8], 16'd0}
            + {w[7:0], 24'd0}
            + {w[15:0], 16'd0}
            + {14'd0, w[31:14]};
        return acc;
    endfunction

    // Sum-independent base of a short tail word; only the valid bytes count.
    function automatic logic [WORD_W-1:0] tail_base(input logic [WORD_W-1:0] w,
                                                    input logic [COUNT_W-1:0] count);
        logic [WORD_W-1:0] acc;
        acc = TAIL_SEED + {w[7:0], 24'd0};
        if (count >= 3'd2)
        begin
            acc = acc + {16'd0, w[15:8], 8'd0};
        end
        if (count >= 3'd3)
        begin
            acc = acc + {7'd0, w[23:16], 17'd0};
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/ssw_premix.sv
// ----------------------------------------------------------------------------
// ssw_premix: input register stage
// Accepts one word per cycle unless stalled and registers its kind together
// with the part of the mixing that does not depend on the running sum.
// ----------------------------------------------------------------------------
module ssw_premix
    import ssw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WORD_W-1:0]   data_word,
    input  logic [COUNT_W-1:0]  valid_bytes,
    input  logic                last,
    input  logic                word_valid,
    output logic                word_stall,
    input  logic                advance,
    output premix_t             stage
);

    premix_t    stage_reg;
    premix_t    stage_next;
    logic       accept;

    // The register is free when empty or when its word moves on this cycle.
    assign word_stall = stage_reg.valid && !advance;
    assign accept     = word_valid && !word_stall;

    // Classify the word and precompute its term.
    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid = 1'b1;
            stage_next.last  = last;
            if (valid_bytes >= COUNT_FULL)
            begin
                stage_next.kind = KIND_FULL;
                stage_next.term = full_term(data_word);
            end
            else if (valid_bytes != '0)
            begin
                stage_next.kind = KIND_TAIL;
                stage_next.term = tail_base(data_word, valid_bytes);
            end
            else
            begin
                stage_next.kind = KIND_NONE;
                stage_next.term = '0;
            end
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
            stage_reg.last  <= 1'b0;
            stage_reg.kind  <= KIND_NONE;
            stage_reg.term  <= '0;
        end
        else
        begin
            stage_reg.valid <= stage_next.valid;
            stage_reg.last  <= stage_next.last;
            stage_reg.kind  <= stage_next.kind;
            stage_reg.term  <= stage_next.term;
        end
    end

    assign stage = stage_reg;

endmodule

>>> hw/rtl/ssw_mix.sv
// ----------------------------------------------------------------------------
// ssw_mix: running sum and result register
// Folds the premixed word into the running sum and, on the last word of a
// payload, loads the checksum into the result register and clears the sum.
// ----------------------------------------------------------------------------
module ssw_mix
    import ssw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  premix_t             stage,
    output logic                advance,
    output logic [WORD_W-1:0]   checksum,
    output logic                checksum_valid,
    input  logic                checksum_stall
);

    logic [WORD_W-1:0]  sum_reg;
    logic [WORD_W-1:0]  sum_next;
    logic [WORD_W-1:0]  mixed;
    logic [WORD_W-1:0]  result_reg;
    logic [WORD_W-1:0]  result_next;
    logic               result_valid_reg;
    logic               result_valid_next;
    logic               result_free;
    logic [WORD_W-1:0]  f1;
    logic [WORD_W-1:0]  t1;
    logic [WORD_W-1:0]  t2;
    logic [WORD_W-1:0]  s1;
    logic [WORD_W-1:0]  s2;

    // A last word may only move on when the result register can take it.
    assign result_free = !result_valid_reg || !checksum_stall;
    assign advance     = stage.valid && (!stage.last || result_free);

    // Sum-dependent part of the mixing for both word kinds.
    always_comb
    begin
        f1 = sum_reg + stage.term;
        t1 = stage.term + (sum_reg >> 7) + (sum_reg << 19);
        t2 = t1 + (t1 << 16) + (t1 >> 16);
        s1 = sum_reg + t2;
        s2 = s1 + (s1 << 16);
        unique case (stage.kind)
            KIND_FULL: mixed = f1 + (f1 << 16) + (f1 >> 11);
            KIND_TAIL: mixed = s2 + (s2 >> 11);
            KIND_NONE: mixed = sum_reg;
            default:   mixed = sum_reg;
        endcase
    end

    // Sum and result register updates.
    always_comb
    begin
        sum_next          = sum_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !checksum_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (advance)
        begin
            if (stage.last)
            begin
                sum_next          = '0;
                result_next       = mixed;
                result_valid_next = 1'b1;
            end
            else
            begin
                sum_next = mixed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign checksum       = result_reg;
    assign checksum_valid = result_valid_reg;

endmodule

>>> hw/rtl/saved_state_word_checksum.sv
// ----------------------------------------------------------------------------
// saved_state_word_checksum: streaming 32-bit payload checksum
// Top level joining the premix input stage and the running sum stage.
// ----------------------------------------------------------------------------
// The block takes one payload word per clock cycle, little-endian, first byte
// in bits 7:0, and keeps a 32-bit running sum that starts at zero. A word with
// four valid bytes uses the full-word rule; a shorter word uses the tail rule;
// a word with no valid bytes leaves the sum unchanged. The word marked last
// yields one checksum word and clears the sum for the next payload. Words are
// taken back to back at one per cycle unless stalled; the checksum is loaded
// into the result register as its last word leaves the input register. The
// rate is set by the running sum register, whose update for one word is
// combinational. A held checksum keeps the next last word waiting in the
// input register, which then stalls the input until the checksum is taken.
module saved_state_word_checksum
    import ssw_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WORD_W-1:0]   data_word,
    input  logic [COUNT_W-1:0]  valid_bytes,
    input  logic                last,
    input  logic                word_valid,
    output logic                word_stall,
    output logic [WORD_W-1:0]   checksum,
    output logic                checksum_valid,
    input  logic                checksum_stall
);

    premix_t    stage;
    logic       advance;

    // Input register with sum-independent premixing.
    ssw_premix u_premix (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .last        (last),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .advance     (advance),
        .stage       (stage)
    );

    // Running sum and checksum result register.
    ssw_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .stage          (stage),
        .advance        (advance),
        .checksum       (checksum),
        .checksum_valid (checksum_valid),
        .checksum_stall (checksum_stall)
    );

endmodule
